>>> hw/rtl/bdec_pkg.sv
// bdec_pkg: types, character codes and helper functions for the bytea text decoder
// used by bdec_step and bytea_text_decoder; depends on nothing else

package bdec_pkg;

	// character codes the decoder reacts to
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LF_HEX = 8'h66;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF_HEX = 8'h46;

	// largest value an octal escape may carry
	localparam logic [8:0] OCT_MAX = 9'h0FF;
	localparam logic [1:0] OCT_DIGITS = 2'd3;

	// error codes on the result beat
	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_BAD_HEX = 2'd1,
		ERR_ODD_HEX = 2'd2,
		ERR_BAD_ESC = 2'd3
	} err_code_t;

	// decoder phase, one-hot
	typedef enum logic [6:0] {
		PH_START    = 7'b0000001,
		PH_START_BS = 7'b0000010,
		PH_ESC      = 7'b0000100,
		PH_ESC_BS   = 7'b0001000,
		PH_ESC_OCT  = 7'b0010000,
		PH_HEX      = 7'b0100000,
		PH_ERR      = 7'b1000000
	} phase_t;

	// input beat
	typedef struct packed {
		logic [7:0] ch;
		logic       char_valid;
		logic       end_of_string;
	} item_t;

	// result beat
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       done_res;
		err_code_t  error_code;
		logic [7:0] bad_char;
	} result_t;

	// decoder state carried from one character to the next
	typedef struct packed {
		phase_t     phase;
		logic [3:0] high_nibble;
		logic       nibble_pending;
		logic [1:0] escape_count;
		logic [8:0] octal_accum;
	} dec_state_t;

	localparam dec_state_t STATE_RESET = '{
		phase:          PH_START,
		high_nibble:    4'd0,
		nibble_pending: 1'b0,
		escape_count:   2'd0,
		octal_accum:    9'd0
	};

	// outcome of one decode step
	typedef struct packed {
		dec_state_t nxt;
		logic       has_result;
		result_t    res;
	} step_out_t;

	function automatic logic is_octal(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_SEVEN);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
			((c >= CH_LA) && (c <= CH_LF_HEX)) ||
			((c >= CH_UA) && (c <= CH_UF_HEX));
	endfunction

	// nibble value of a hex digit; letters map by their low bits plus nine
	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [3:0] v;
		if (c <= CH_NINE) begin
			v = c[3:0];
		end else begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

endpackage

>>> hw/rtl/bdec_step.sv
// bdec_step: combinational decode of one character against the current state
// depends on bdec_pkg for the item, result and state types

module bdec_step (
	input  bdec_pkg::dec_state_t st,
	input  bdec_pkg::item_t      item,
	output bdec_pkg::step_out_t  step
);

	logic [7:0]          ch;
	logic                eos;
	bdec_pkg::dec_state_t nxt;
	bdec_pkg::err_code_t err;
	logic [7:0]          bad;
	logic [7:0]          b;
	logic                have;
	logic [8:0]          acc_new;
	logic [1:0]          cnt_new;
	bdec_pkg::err_code_t end_code;

	assign ch      = item.ch;
	assign eos     = item.end_of_string;
	assign acc_new = {st.octal_accum[5:0], ch[2:0]};
	assign cnt_new = st.escape_count + 2'd1;

	// per-character phase update
	always_comb begin
		nxt  = st;
		err  = bdec_pkg::ERR_NONE;
		bad  = 8'd0;
		b    = 8'd0;
		have = 1'b0;
		if (item.char_valid && (st.phase != bdec_pkg::PH_ERR)) begin
			case (st.phase)
				bdec_pkg::PH_START: begin
					if (ch == bdec_pkg::CH_BSLASH) begin
						nxt.phase = bdec_pkg::PH_START_BS;
					end else begin
						nxt.phase = bdec_pkg::PH_ESC;
						b = ch;
						have = 1'b1;
					end
				end
				bdec_pkg::PH_START_BS, bdec_pkg::PH_ESC_BS: begin
					if ((st.phase == bdec_pkg::PH_START_BS) && (ch == bdec_pkg::CH_X)) begin
						nxt.phase = bdec_pkg::PH_HEX;
					end else if (ch == bdec_pkg::CH_BSLASH) begin
						nxt.phase = bdec_pkg::PH_ESC;
						b = bdec_pkg::CH_BSLASH;
						have = 1'b1;
					end else if (bdec_pkg::is_octal(ch)) begin
						nxt.phase = bdec_pkg::PH_ESC_OCT;
						nxt.escape_count = 2'd1;
						nxt.octal_accum = {6'd0, ch[2:0]};
					end else begin
						err = bdec_pkg::ERR_BAD_ESC;
					end
				end
				bdec_pkg::PH_ESC: begin
					if (ch == bdec_pkg::CH_BSLASH) begin
						nxt.phase = bdec_pkg::PH_ESC_BS;
					end else begin
						b = ch;
						have = 1'b1;
					end
				end
				bdec_pkg::PH_ESC_OCT: begin
					if (!bdec_pkg::is_octal(ch)) begin
						err = bdec_pkg::ERR_BAD_ESC;
					end else begin
						nxt.octal_accum = acc_new;
						nxt.escape_count = cnt_new;
						if (cnt_new == bdec_pkg::OCT_DIGITS) begin
							if (acc_new > bdec_pkg::OCT_MAX) begin
								err = bdec_pkg::ERR_BAD_ESC;
							end else begin
								b = acc_new[7:0];
								have = 1'b1;
								nxt.phase = bdec_pkg::PH_ESC;
								nxt.escape_count = 2'd0;
								nxt.octal_accum = 9'd0;
							end
						end
					end
				end
				bdec_pkg::PH_HEX: begin
					// whitespace is skipped only between pairs
					if (!st.nibble_pending && bdec_pkg::is_space(ch)) begin
						nxt = st;
					end else if (!bdec_pkg::is_hex(ch)) begin
						err = bdec_pkg::ERR_BAD_HEX;
						bad = ch;
					end else if (!st.nibble_pending) begin
						nxt.high_nibble = bdec_pkg::hex_nibble(ch);
						nxt.nibble_pending = 1'b1;
					end else begin
						b = {st.high_nibble, bdec_pkg::hex_nibble(ch)};
						have = 1'b1;
						nxt.nibble_pending = 1'b0;
						nxt.high_nibble = 4'd0;
					end
				end
				default: begin
					nxt = bdec_pkg::STATE_RESET;
				end
			endcase
		end
	end

	// check for an unfinished escape or hex pair at the end of the string
	always_comb begin
		end_code = bdec_pkg::ERR_NONE;
		if ((nxt.phase == bdec_pkg::PH_START_BS) || (nxt.phase == bdec_pkg::PH_ESC_BS) ||
			(nxt.phase == bdec_pkg::PH_ESC_OCT)) begin
			end_code = bdec_pkg::ERR_BAD_ESC;
		end else if ((nxt.phase == bdec_pkg::PH_HEX) && nxt.nibble_pending) begin
			end_code = bdec_pkg::ERR_ODD_HEX;
		end
	end

	// result and final state
	always_comb begin
		step.nxt = nxt;
		step.has_result = 1'b0;
		step.res.out_byte = 8'd0;
		step.res.byte_valid = 1'b0;
		step.res.done_res = 1'b0;
		step.res.error_code = bdec_pkg::ERR_NONE;
		step.res.bad_char = 8'd0;
		if (st.phase == bdec_pkg::PH_ERR) begin
			// swallow everything up to the end item
			step.nxt = eos ? bdec_pkg::STATE_RESET : st;
		end else if (err != bdec_pkg::ERR_NONE) begin
			if (eos) begin
				step.nxt = bdec_pkg::STATE_RESET;
			end else begin
				step.nxt.phase = bdec_pkg::PH_ERR;
			end
			step.has_result = 1'b1;
			step.res.done_res = 1'b1;
			step.res.error_code = err;
			step.res.bad_char = bad;
		end else if (eos) begin
			step.nxt = bdec_pkg::STATE_RESET;
			step.has_result = 1'b1;
			step.res.done_res = 1'b1;
			step.res.error_code = end_code;
			if (end_code == bdec_pkg::ERR_NONE) begin
				step.res.out_byte = b;
				step.res.byte_valid = have;
			end
		end else if (have) begin
			step.has_result = 1'b1;
			step.res.out_byte = b;
			step.res.byte_valid = 1'b1;
		end
	end

endmodule

>>> hw/rtl/bytea_text_decoder.sv
// bytea_text_decoder: top level, input stage, decoder state and result register
// depends on bdec_pkg and bdec_step

// Decodes a text string, one character per beat, into binary bytes: a string that
// opens with backslash and lower-case x is hex, anything else is escape format. The
// block takes one character every clock cycle while item_stall is low. Each beat is
// captured in an input stage, decoded against the running state and written to the
// result register, which drives the result port.
// The combinational decode step and the one-deep result register set this rate: input
// is stalled only while a beat that makes a result waits for a stalled result
// register. Beats that make no byte (hex prefix, whitespace, escape digits) give no
// result beat unless they end the string or raise an error; every string ends in
// exactly one beat with done_res set.

module bytea_text_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  bdec_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output bdec_pkg::result_t result
);

	bdec_pkg::item_t      item_s1;
	logic                 valid_s1;
	bdec_pkg::dec_state_t state_q;
	bdec_pkg::result_t    result_q;
	logic                 result_valid_q;
	bdec_pkg::step_out_t  step;
	logic                 out_free;
	logic                 advance;
	logic                 accept;

	// decode step on the staged character
	bdec_step u_step (
		.st   (state_q),
		.item (item_s1),
		.step (step)
	);

	// flow control
	assign out_free   = !result_valid_q || !result_stall;
	assign advance    = valid_s1 && (!step.has_result || out_free);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdec_pkg::STATE_RESET;
		end else if (advance) begin
			state_q <= step.nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && step.has_result) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step.has_result) begin
			result_q <= step.res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// an error result always ends the string and carries no byte
	a_err_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && (result_q.error_code != bdec_pkg::ERR_NONE)) |->
		(result_q.done_res && !result_q.byte_valid))
		else $error("error result without done or with a byte");

	// bad_char only reports a bad hex digit
	a_bad_char_code: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && (result_q.bad_char != 8'd0)) |->
		(result_q.error_code == bdec_pkg::ERR_BAD_HEX))
		else $error("bad_char set without a bad hex digit error");

	// after a done result the decoder is back at string start or swallowing input
	a_done_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step.has_result && step.res.done_res) |=>
		((state_q.phase == bdec_pkg::PH_START) || (state_q.phase == bdec_pkg::PH_ERR)))
		else $error("decoder state not reset after done result");

	// a result is never overwritten while it waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_stall) |-> !(advance && step.has_result))
		else $error("result register overwritten while stalled");

endmodule
